// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the deframer RTL.
// Each check is a concurrent assertion clocked on the rising edge and
// disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/htfe_pkg.sv =====
package htfe_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 11;
   localparam int HEAD_W    = 40;
   localparam int TAIL_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_PATTERN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_PATTERN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD  = 2'd2;

   localparam logic [HEAD_W-1:0] HEAD_RESET = 40'h0D0A2B723D;
   localparam logic [TAIL_W-1:0] TAIL_RESET = 16'h0D0A;
   localparam logic [LEN_W-1:0]  MAX_RESET  = 11'd1024;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_END      = 2'd1,
      KIND_OVERFLOW = 2'd2,
      KIND_ABORT    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              buffer_end;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  frame_length;
   } rsp_type;

   typedef struct packed {
      logic [HEAD_W-1:0] head_pattern;
      logic [TAIL_W-1:0] tail_pattern;
      logic [LEN_W-1:0]  max_payload;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } push_type;

endpackage

// ===== rtl/core/htfe_csr.sv =====
module htfe_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [htfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [htfe_pkg::CSR_DAT_W-1:0]      csr_wdata,
   output htfe_pkg::cfg_type                   cfg
);

   htfe_pkg::cfg_type cfg_ff;
   htfe_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            htfe_pkg::CSR_HEAD_PATTERN: begin
               cfg_in.head_pattern = csr_wdata[htfe_pkg::HEAD_W-1:0];
            end
            htfe_pkg::CSR_TAIL_PATTERN: begin
               cfg_in.tail_pattern = csr_wdata[htfe_pkg::TAIL_W-1:0];
            end
            htfe_pkg::CSR_MAX_PAYLOAD: begin
               cfg_in.max_payload = csr_wdata[htfe_pkg::LEN_W-1:0];
            end
            default: begin
               // unmapped index: drop the write
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_pattern <= htfe_pkg::HEAD_RESET;
         cfg_ff.tail_pattern <= htfe_pkg::TAIL_RESET;
         cfg_ff.max_payload  <= htfe_pkg::MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/htfe_deframe.sv =====
`include "assert_macros.svh"
module htfe_deframe #(
   parameter int HEAD_BYTES    = 5,
   parameter int PAYLOAD_LIMIT = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  htfe_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  htfe_pkg::req_type  req_data,
   input  logic               buf_ready,
   output htfe_pkg::push_type push
);

   localparam int ByteW = htfe_pkg::BYTE_W;
   localparam int LenW  = htfe_pkg::LEN_W;
   localparam int HeadW = htfe_pkg::HEAD_W;
   localparam int HW    = HEAD_BYTES * ByteW;
   localparam int CW    = (HW > HeadW) ? HW : HeadW;
   localparam int FillW = $clog2(HEAD_BYTES + 1);
   localparam int CntW  = $clog2(PAYLOAD_LIMIT + 1);
   localparam int LimW  = (CntW > LenW) ? CntW : LenW;
   localparam logic [FillW-1:0] FillTop  = FillW'(HEAD_BYTES - 1);
   localparam logic [LimW-1:0]  LimitCap = LimW'(PAYLOAD_LIMIT);
   localparam logic [CW-1:0]    CmpMask  = {CW{1'b1}} >> (CW - HW);

   // input register
   logic              in_valid_ff;
   htfe_pkg::req_type in_data_ff;
   logic              advance;

   // deframing state
   logic             in_frame_ff, in_frame_in;
   logic [HW-1:0]    win_ff, win_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [ByteW-1:0] held_byte_ff, held_byte_in;
   logic             held_valid_ff, held_valid_in;
   logic [CntW-1:0]  count_ff, count_in;

   logic [HW-1:0]    full;
   logic             matched;
   logic             tail_hit;
   logic             over;
   logic             hunt;
   logic [LimW-1:0]  max_ext;
   logic [LimW-1:0]  limit;
   logic [ByteW-1:0] rx;
   logic             last;

   assign advance   = in_valid_ff && buf_ready;
   assign req_ready = !in_valid_ff || buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   assign rx      = in_data_ff.rx_byte;
   assign last    = in_data_ff.buffer_end;
   assign full    = HW'({win_ff, rx});
   assign matched = (fill_ff >= FillTop) &&
                    (((CW'(full) ^ CW'(cfg.head_pattern)) & CmpMask) == '0);
   assign tail_hit = held_valid_ff &&
                     (held_byte_ff == cfg.tail_pattern[15:8]) &&
                     (rx == cfg.tail_pattern[7:0]);
   assign max_ext = LimW'(cfg.max_payload);
   assign limit   = (max_ext > LimitCap) ? LimitCap : max_ext;
   assign over    = LimW'(count_ff) >= limit;

   always_comb begin
      in_frame_in   = in_frame_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      hunt          = 1'b0;
      push.valid    = 1'b0;
      push.item.kind         = htfe_pkg::KIND_PAYLOAD;
      push.item.payload_byte = '0;
      push.item.frame_length = '0;
      if (advance) begin
         if (!in_frame_ff) begin
            win_in = full;
            if (fill_ff < FillTop) begin
               fill_in = fill_ff + 1'b1;
            end
            if (matched) begin
               in_frame_in   = 1'b1;
               win_in        = '0;
               fill_in       = '0;
               held_byte_in  = '0;
               held_valid_in = 1'b0;
               count_in      = '0;
               if (last) begin
                  push.valid     = 1'b1;
                  push.item.kind = htfe_pkg::KIND_ABORT;
               end
            end
         end else if (tail_hit) begin
            push.valid             = 1'b1;
            push.item.kind         = htfe_pkg::KIND_END;
            push.item.frame_length = LenW'(count_ff);
            hunt                   = 1'b1;
         end else if (last) begin
            push.valid     = 1'b1;
            push.item.kind = htfe_pkg::KIND_ABORT;
            hunt           = 1'b1;
         end else if (held_valid_ff && over) begin
            push.valid     = 1'b1;
            push.item.kind = htfe_pkg::KIND_OVERFLOW;
            hunt           = 1'b1;
         end else begin
            // emit the byte held back, hold the new one
            if (held_valid_ff) begin
               push.valid             = 1'b1;
               push.item.payload_byte = held_byte_ff;
               count_in               = count_ff + 1'b1;
            end
            held_byte_in  = rx;
            held_valid_in = 1'b1;
         end
         if (hunt || last) begin
            in_frame_in   = 1'b0;
            win_in        = '0;
            fill_in       = '0;
            held_byte_in  = '0;
            held_valid_in = 1'b0;
            count_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         win_ff        <= '0;
         fill_ff       <= '0;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         win_ff        <= win_in;
         fill_ff       <= fill_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
      end
   end

   `ASSERT_IMPLY(a_held_in_frame, clock, reset, held_valid_ff, in_frame_ff)
   `ASSERT_IMPLY(a_hunt_count_zero, clock, reset, !in_frame_ff, count_ff == '0)
   `ASSERT_PROP(a_count_bounded, clock, reset, LimW'(count_ff) <= LimitCap)
   `ASSERT_IMPLY(a_push_needs_item, clock, reset, push.valid, advance)

endmodule

// ===== rtl/core/htfe_rsp_buf.sv =====
`include "assert_macros.svh"
module htfe_rsp_buf (
   input  logic               clock,
   input  logic               reset,
   input  htfe_pkg::push_type push,
   output logic               buf_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output htfe_pkg::rsp_type  rsp_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   htfe_pkg::rsp_type main_ff, main_in;
   htfe_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign buf_ready = !skid_valid_ff;
   assign pop       = main_valid_ff && rsp_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no push is taken while the skid slot is full
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = push.item;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push.item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   `ASSERT_IMPLY(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   `ASSERT_IMPLY(a_no_push_when_full, clock, reset, skid_valid_ff, !push.valid)
   `ASSERT_IMPLY(a_skid_fills_on_stall, clock, reset,
      push.valid && main_valid_ff && !rsp_ready, ##1 skid_valid_ff)

endmodule

// ===== rtl/core/head_tail_frame_extractor.sv =====
// Head/tail deframer for a received byte stream.
// req channel: one beat per received byte (rx_byte) with a buffer_end flag
// marking the last byte of a software buffer. rsp channel: one beat per
// event: payload byte, frame end with payload length, payload overflow or
// frame aborted. Many request beats give no response beat (head bytes,
// hunting bytes, the first byte of a frame, which is held back one beat).
// csr port: single-cycle writes to head pattern, tail pattern and maximum
// payload length; write these only while no beat is in flight.
// Request beats pass through the input register, then the response buffer,
// before their responses are presented. Throughput: one request beat per
// cycle while req_ready is high; the hunt compare and the held-byte update
// are both combinational between the input register and the response
// buffer.
// When rsp_ready is low the two-entry response buffer absorbs one more
// result, then req_ready drops until the receiver drains it.
// Reset returns the configuration to its defaults, clears the head window
// and starts hunting for a head.
module head_tail_frame_extractor #(
   parameter int HEAD_BYTES    = 5,
   parameter int PAYLOAD_LIMIT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  htfe_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output htfe_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [htfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [htfe_pkg::CSR_DAT_W-1:0] csr_wdata
);

   htfe_pkg::cfg_type  cfg;
   htfe_pkg::push_type push;
   logic               buf_ready;

   htfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   htfe_deframe #(
      .HEAD_BYTES    (HEAD_BYTES),
      .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
   ) u_deframe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .buf_ready (buf_ready),
      .push      (push)
   );

   htfe_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .buf_ready (buf_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
